// ===== hdl/crt_solver_assert.svh =====
// Assertion macros shared by the solver modules.
`ifndef CRT_SOLVER_ASSERT_SVH
`define CRT_SOLVER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/crt_pkg.sv =====
// Shared constants and types of the CRT solver.
package crt_pkg;
  localparam int MAX_CONG_DEF = 4;
  localparam int MOD_W_DEF = 16;
  localparam int FIELD_W = 16;
  localparam int WIDE_W = 64;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_COPRIME = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_MOD = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd3;

  // divider request/response bundle
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

// ===== hdl/crt_if.sv =====
// Valid/ready channel interfaces of the CRT solver.
interface crt_in_if;
  logic valid;
  logic ready;
  logic [crt_pkg::FIELD_W-1:0] modulus;
  logic [crt_pkg::FIELD_W-1:0] remainder;
  logic last_item;
  modport source (output valid, modulus, remainder, last_item, input ready);
  modport sink (input valid, modulus, remainder, last_item, output ready);
endinterface

interface crt_out_if;
  logic valid;
  logic ready;
  logic [crt_pkg::WIDE_W-1:0] solution;
  logic [crt_pkg::WIDE_W-1:0] product;
  logic [crt_pkg::STAT_W-1:0] status;
  modport source (output valid, solution, product, status, input ready);
  modport sink (input valid, solution, product, status, output ready);
endinterface

// ===== hdl/crt_solver.sv =====
// Chinese remainder solver: takes up to MAX_CONGRUENCES (modulus, remainder) words; the
// word flagged last_item starts the solve and one result word follows. The solve runs
// every division, modulo and Euclid quotient through one shared 64-bit bit-serial
// divider plus a 16 by 64-bit multiply; per congruence 4 + E divisions where E is the
// number of Euclid steps (E <= about 24 for 16-bit moduli), plus steps that do not use
// the divider. The input is not ready while a solve is running or a result waits.
module crt_solver #(
  parameter int MAX_CONGRUENCES = crt_pkg::MAX_CONG_DEF,
  parameter int MODULUS_WIDTH = crt_pkg::MOD_W_DEF
) (
  input logic clk,
  input logic rst_n,
  crt_in_if.sink in_ch,
  crt_out_if.source out_ch
);
  localparam int W = crt_pkg::WIDE_W;
  localparam int MW = MODULUS_WIDTH;
  localparam int IW = $clog2(MAX_CONGRUENCES);
  localparam int CW = $clog2(MAX_CONGRUENCES + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PART  = 12'b000000000010, // part = N / n_i
    S_PMOD  = 12'b000000000100, // a = part % n_i
    S_EUC   = 12'b000000001000, // q = old_r / r
    S_EUPD  = 12'b000000010000, // update r and s
    S_INVM  = 12'b000000100000, // reduce old_s to inverse
    S_RMOD  = 12'b000001000000, // ri % ni
    S_TMUL  = 12'b000010000000, // ri * inv
    S_TMOD  = 12'b000100000000, // (ri*inv) % ni
    S_ACC   = 12'b001000000000, // sum add
    S_NEXT  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t st_r, st_nxt;
  logic [MW-1:0] mod_mem [MAX_CONGRUENCES];
  logic [MW-1:0] rem_mem [MAX_CONGRUENCES];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [W-1:0] prod_r, prod_nxt, sum_r, sum_nxt, part_r, part_nxt;
  logic [1:0] err_r, err_nxt;
  logic [MW-1:0] oldr_r, oldr_nxt, rr_r, rr_nxt, ri_r, ri_nxt, inv_r, inv_nxt;
  logic signed [MW+1:0] olds_r, olds_nxt, ss_r, ss_nxt;
  logic [MW-1:0] qq;
  logic [W-1:0] term_r, term_nxt;
  logic [W-1:0] sol_r, sol_nxt;
  logic [W-1:0] oprod_r, oprod_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic ov_r, ov_nxt;
  crt_pkg::div_ctl_t dctl;
  crt_pkg::div_sts_t dsts;
  logic [W-1:0] dvd, dvs, dq, drm;
  logic [MW-1:0] n_in, r_in, ni;
  logic acc_in;
  logic [W-1:0] room;
  logic signed [2*MW+3:0] sprod;

  assign n_in = in_ch.modulus[MW-1:0];
  assign r_in = in_ch.remainder[MW-1:0];
  assign in_ch.ready = (st_r == S_IDLE) && !ov_r;
  assign acc_in = in_ch.valid && in_ch.ready;
  assign ni = mod_mem[idx_r];
  assign qq = dq[MW-1:0];
  assign room = prod_r - term_r;
  assign sprod = (2*MW+4)'($signed({1'b0, qq})) * (2*MW+4)'(ss_r);

  crt_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
    .sts(dsts), .quot(dq), .rem(drm)
  );

  always_ff @(posedge clk) begin
    if (acc_in && n_in != '0 && cnt_r < CW'(MAX_CONGRUENCES)) begin
      mod_mem[cnt_r[IW-1:0]] <= n_in;
      rem_mem[cnt_r[IW-1:0]] <= r_in;
    end
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    prod_nxt = prod_r;
    sum_nxt = sum_r;
    part_nxt = part_r;
    err_nxt = err_r;
    oldr_nxt = oldr_r;
    rr_nxt = rr_r;
    olds_nxt = olds_r;
    ss_nxt = ss_r;
    ri_nxt = ri_r;
    inv_nxt = inv_r;
    term_nxt = term_r;
    sol_nxt = sol_r;
    oprod_nxt = oprod_r;
    ostat_nxt = ostat_r;
    ov_nxt = ov_r;
    dctl.start = 1'b0;
    dvd = '0;
    dvs = W'(ni);
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (acc_in) begin
          if (n_in == '0) begin
            if (err_r == crt_pkg::ST_OK) err_nxt = crt_pkg::ST_ZERO_MOD;
          end else if (cnt_r >= CW'(MAX_CONGRUENCES)) begin
            if (err_r == crt_pkg::ST_OK) err_nxt = crt_pkg::ST_TOO_MANY;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            prod_nxt = prod_r * W'(n_in);
          end
          if (in_ch.last_item) begin
            idx_nxt = '0;
            sum_nxt = '0;
            st_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (err_r != crt_pkg::ST_OK || CW'(idx_r) >= cnt_r) begin
          st_nxt = S_OUT;
        end else begin
          dctl.start = 1'b1;
          dvd = prod_r;
          st_nxt = S_PART;
        end
      end
      S_PART: begin
        if (dsts.done) begin
          part_nxt = dq;
          dctl.start = 1'b1;
          dvd = dq;
          st_nxt = S_PMOD;
        end
      end
      S_PMOD: begin
        if (dsts.done) begin
          oldr_nxt = drm[MW-1:0];
          rr_nxt = ni;
          olds_nxt = (MW+2)'(1);
          ss_nxt = '0;
          st_nxt = S_EUC;
        end
      end
      S_EUC: begin
        if (!dsts.busy && !dsts.done) begin
          if (rr_r == '0) begin
            if (oldr_r != MW'(1)) begin
              err_nxt = crt_pkg::ST_NOT_COPRIME;
              st_nxt = S_NEXT;
            end else begin
              st_nxt = S_INVM;
            end
          end else begin
            dctl.start = 1'b1;
            dvd = W'(oldr_r);
            dvs = W'(rr_r);
            st_nxt = S_EUPD;
          end
        end
      end
      S_EUPD: begin
        if (dsts.done) begin
          oldr_nxt = rr_r;
          rr_nxt = drm[MW-1:0];
          olds_nxt = ss_r;
          ss_nxt = olds_r - (MW+2)'(sprod);
          st_nxt = S_EUC;
        end
      end
      S_INVM: begin
        // Bezout coefficient lies in (-n, n)
        if (olds_r[MW+1]) inv_nxt = MW'(olds_r + (MW+2)'(ni));
        else inv_nxt = MW'(olds_r);
        dctl.start = 1'b1;
        dvd = W'(rem_mem[idx_r]);
        st_nxt = S_RMOD;
      end
      S_RMOD: begin
        if (dsts.done) begin
          ri_nxt = drm[MW-1:0];
          st_nxt = S_TMUL;
        end
      end
      S_TMUL: begin
        dctl.start = 1'b1;
        dvd = W'(ri_r * inv_r);
        st_nxt = S_TMOD;
      end
      S_TMOD: begin
        if (dsts.done) begin
          // t < n_i, so t * part < N
          term_nxt = part_r * W'(drm[MW-1:0]);
          st_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sum_nxt = (sum_r >= room) ? sum_r - room : sum_r + term_r;
        idx_nxt = (CW'(idx_r) + 1'b1 >= CW'(MAX_CONGRUENCES)) ? idx_r : IW'(idx_r + 1'b1);
        if (CW'(idx_r) + 1'b1 >= CW'(MAX_CONGRUENCES)) begin
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_NEXT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          sol_nxt = (err_r == crt_pkg::ST_OK) ? sum_r : '0;
          oprod_nxt = prod_r;
          ostat_nxt = err_r;
          ov_nxt = 1'b1;
          cnt_nxt = '0;
          prod_nxt = W'(1);
          err_nxt = crt_pkg::ST_OK;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    part_r <= part_nxt;
    oldr_r <= oldr_nxt;
    rr_r <= rr_nxt;
    olds_r <= olds_nxt;
    ss_r <= ss_nxt;
    ri_r <= ri_nxt;
    inv_r <= inv_nxt;
    term_r <= term_nxt;
    sol_r <= sol_nxt;
    oprod_r <= oprod_nxt;
    ostat_r <= ostat_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      prod_r <= W'(1);
      err_r <= crt_pkg::ST_OK;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      prod_r <= prod_nxt;
      err_r <= err_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.solution = sol_r;
  assign out_ch.product = oprod_r;
  assign out_ch.status = ostat_r;

`include "crt_solver_assert.svh"
  `CRT_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_CONGRUENCES))
  `CRT_ASSERT_NXT(a_out_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r && $stable(sol_r))
  `CRT_ASSERT_IMP(a_div_idle_ready, clk, rst_n, in_ch.ready, !dsts.busy)
  `CRT_ASSERT_IMP(a_ok_sol, clk, rst_n, ov_r && ostat_r != crt_pkg::ST_OK, sol_r == '0)
endmodule

// ===== hdl/crt_div.sv =====
// Shared restoring divider: 64-bit dividend by 64-bit divisor, one bit a cycle.
module crt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crt_pkg::div_ctl_t             ctl,
  input  logic [crt_pkg::WIDE_W-1:0]    dividend,
  input  logic [crt_pkg::WIDE_W-1:0]    divisor,
  output crt_pkg::div_sts_t             sts,
  output logic [crt_pkg::WIDE_W-1:0]    quot,
  output logic [crt_pkg::WIDE_W-1:0]    rem
);
  localparam int W = crt_pkg::WIDE_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0] shl;
  logic [W:0] diff;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shl = {r_r, q_r[W-1]};
    diff = shl - {1'b0, d_r};
    if (ctl.start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        r_nxt = diff[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = shl[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot = q_r;
  assign rem = r_r;

`include "crt_solver_assert.svh"
  `CRT_ASSERT_IMP(a_div_done_idle, clk, rst_n, done_r, !busy_r)
  `CRT_ASSERT_NXT(a_div_start_busy, clk, rst_n, ctl.start, busy_r)
  `CRT_ASSERT_IMP(a_div_cnt, clk, rst_n, busy_r, cnt_r != '0)
endmodule

// ===== bench/crt_solver_test.sv =====
// Testbench of crt_solver: directed and random congruence systems, checked against a predictor.
module crt_solver_test;
  typedef struct {
    logic [crt_pkg::WIDE_W-1:0] solution;
    logic [crt_pkg::WIDE_W-1:0] product;
    logic [crt_pkg::STAT_W-1:0] status;
  } crt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  crt_in_if in_ch();
  crt_out_if out_ch();

  crt_solver uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the block state
  logic [crt_pkg::FIELD_W-1:0] mod_seen [crt_pkg::MAX_CONG_DEF];
  logic [crt_pkg::FIELD_W-1:0] rem_seen [crt_pkg::MAX_CONG_DEF];
  int unsigned cong_count;
  logic [crt_pkg::WIDE_W-1:0] prod_acc;
  logic [crt_pkg::STAT_W-1:0] first_err;

  crt_result_t results_due[$];
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned hold_left = 0;
  bit no_idle = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic int unsigned gcd16(input int unsigned a, input int unsigned b);
    int unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // extended Euclid; returns 0 when a has no inverse modulo m
  function automatic bit euclid_inverse(input longint a, input longint m, output longint inv);
    longint old_r, r, old_s, s, q, t;
    old_r = a; r = m; old_s = 1; s = 0;
    while (r != 0) begin
      q = old_r / r;
      t = old_r - q * r; old_r = r; r = t;
      t = old_s - q * s; old_s = s; s = t;
    end
    inv = 0;
    if (old_r != 1) return 1'b0;
    inv = ((old_s % m) + m) % m;
    return 1'b1;
  endfunction

  task automatic predict_word(input logic [crt_pkg::FIELD_W-1:0] m,
                              input logic [crt_pkg::FIELD_W-1:0] r, input logic last);
    logic [crt_pkg::WIDE_W-1:0] sum, part, ni, ri, term, room;
    longint inv;
    crt_result_t res;
    if (m == 0) begin
      if (first_err == crt_pkg::ST_OK) first_err = crt_pkg::ST_ZERO_MOD;
    end else if (cong_count >= crt_pkg::MAX_CONG_DEF) begin
      if (first_err == crt_pkg::ST_OK) first_err = crt_pkg::ST_TOO_MANY;
    end else begin
      mod_seen[cong_count] = m;
      rem_seen[cong_count] = r;
      cong_count++;
      prod_acc = prod_acc * m;
    end
    if (!last) return;
    sum = 0;
    for (int i = 0; i < cong_count && first_err == crt_pkg::ST_OK; i++) begin
      ni = mod_seen[i];
      ri = rem_seen[i] % ni;
      part = prod_acc / ni;
      if (!euclid_inverse(longint'(part % ni), longint'(ni), inv)) begin
        first_err = crt_pkg::ST_NOT_COPRIME;
        break;
      end
      term = ((ri * inv) % ni) * part;
      room = prod_acc - term;
      sum = (sum >= room) ? sum - room : sum + term;
    end
    res.solution = (first_err == crt_pkg::ST_OK) ? sum : '0;
    res.product = prod_acc;
    res.status = first_err;
    results_due.push_back(res);
    cong_count = 0;
    prod_acc = 1;
    first_err = crt_pkg::ST_OK;
  endtask

  task automatic send_word(input logic [crt_pkg::FIELD_W-1:0] m,
                           input logic [crt_pkg::FIELD_W-1:0] r, input logic last);
    if (!no_idle && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.modulus <= m;
    in_ch.remainder <= r;
    in_ch.last_item <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(m, r, last);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    wait (results_due.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [crt_pkg::FIELD_W-1:0] rand_modulus();
    int unsigned w;
    w = $urandom_range(1, 16);
    return crt_pkg::FIELD_W'($urandom_range(1, (1 << w) - 1));
  endfunction

  // well-formed system: moduli meant to be pairwise coprime (up to 30 tries each), random remainders
  task automatic send_coprime_system(input int unsigned len);
    logic [crt_pkg::FIELD_W-1:0] picked [crt_pkg::MAX_CONG_DEF];
    logic [crt_pkg::FIELD_W-1:0] m;
    bit ok;
    for (int i = 0; i < len; i++) begin
      for (int tries = 0; tries < 30; tries++) begin
        m = rand_modulus();
        ok = 1'b1;
        for (int j = 0; j < i; j++)
          if (gcd16(m, picked[j]) != 1) ok = 1'b0;
        if (ok) break;
      end
      picked[i] = m;
      send_word(m, crt_pkg::FIELD_W'($urandom), i == len - 1);
    end
  endtask

  // noise: any moduli, zeros, overlong systems
  task automatic send_noisy_system();
    int unsigned len;
    logic [crt_pkg::FIELD_W-1:0] m;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: m = '0;
        1, 2: m = crt_pkg::FIELD_W'($urandom_range(2, 12)) * 2;
        default: m = crt_pkg::FIELD_W'($urandom);
      endcase
      send_word(m, crt_pkg::FIELD_W'($urandom), i == len - 1);
    end
  endtask

  always @(posedge clk) begin
    crt_result_t exp_res;
    if (out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        report($sformatf("unexpected result word sol=%0h", out_ch.solution));
      end else begin
        exp_res = results_due.pop_front();
        if (out_ch.solution !== exp_res.solution)
          report($sformatf("solution %0h, want %0h", out_ch.solution, exp_res.solution));
        if (out_ch.product !== exp_res.product)
          report($sformatf("product %0h, want %0h", out_ch.product, exp_res.product));
        if (out_ch.status !== exp_res.status)
          report($sformatf("status %0d, want %0d", out_ch.status, exp_res.status));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && (no_idle || $urandom_range(99) >= 33);
    end
  end

  task automatic test_directed();
    send_word(16'hFFFF, 16'hFFFF, 1'b1);
    send_word(16'd1, 16'd0, 1'b1);          // modulus one alone
    send_word(16'd3, 16'd2, 1'b0);
    send_word(16'd1, 16'hFFFF, 1'b0);       // modulus one in a system
    send_word(16'd5, 16'd3, 1'b1);
    send_word(16'hFFFF, 16'h0000, 1'b0);    // largest coprime moduli
    send_word(16'hFFFE, 16'hFFFF, 1'b0);
    send_word(16'hFFFD, 16'h8000, 1'b0);
    send_word(16'hFFFB, 16'h7FFF, 1'b1);
    send_word(16'd0, 16'd5, 1'b1);          // zero modulus on the last word
    send_word(16'd7, 16'd3, 1'b0);
    send_word(16'd0, 16'd1, 1'b0);
    send_word(16'd11, 16'd2, 1'b1);
    for (int i = 0; i < 5; i++)             // too many congruences
      send_word(crt_pkg::FIELD_W'(2 * i + 3), crt_pkg::FIELD_W'(i), i == 4);
    send_word(16'd6, 16'd1, 1'b0);          // not coprime
    send_word(16'd4, 16'd3, 1'b1);
    send_word(16'd0, 16'd0, 1'b0);          // first error wins
    send_word(16'd6, 16'd1, 1'b0);
    send_word(16'd9, 16'd2, 1'b1);
    send_word(16'd7, 16'hFFFF, 1'b1);       // remainder above modulus
    wait_drained();
  endtask

  task automatic test_random(input int unsigned target);
    while (words_sent < target) begin
      if ($urandom_range(99) < 80)
        send_coprime_system($urandom_range(1, crt_pkg::MAX_CONG_DEF));
      else send_noisy_system();
    end
  endtask

  task automatic test_backpressure();
    hold_left = 600;
    for (int i = 0; i < 6; i++) send_coprime_system($urandom_range(2, crt_pkg::MAX_CONG_DEF));
    wait_drained();
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) send_coprime_system($urandom_range(1, crt_pkg::MAX_CONG_DEF));
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    cong_count = 0;
    prod_acc = 1;
    first_err = crt_pkg::ST_OK;
    in_ch.valid <= 1'b0;
    in_ch.modulus <= '0;
    in_ch.remainder <= '0;
    in_ch.last_item <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_no_idle();
    test_random(1850);
    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("** crt_solver: PASSED **");
    else $display("** crt_solver: FAILED **");
    $finish;
  end

  initial begin
    #120000000;
    $display("** crt_solver: FAILED **");
    $finish;
  end
endmodule
